### rtl/char_lcd_refresh_queue_unit_macros.svh
// Assertion macros for the character display refresh queue
`ifndef CHAR_LCD_REFRESH_QUEUE_UNIT_MACROS_SVH
`define CHAR_LCD_REFRESH_QUEUE_UNIT_MACROS_SVH
// implication checked on every edge out of reset
`define CLQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define CLQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

### rtl/clq_pkg.sv
// Shared types and constants for the character display refresh queue
package clq_pkg;
  localparam logic [1:0] REQ_CHAR = 2'd0;
  localparam logic [1:0] REQ_POST = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic [1:0] K_CURSOR_POS  = 2'd0;
  localparam logic [1:0] K_UPDATE      = 2'd1;
  localparam logic [1:0] K_CURSOR_MODE = 2'd2;
  localparam logic [1:0] K_FUNCTION    = 2'd3;

  localparam logic [7:0] LCD_FUNCTION = 8'h38;
  localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
  localparam logic [7:0] LCD_LINE2    = 8'hC0;

  function automatic logic [7:0] mode_byte(input logic [7:0] code);
    logic [7:0] r;
    case (code)
      8'd0: r = 8'h0C;
      8'd1: r = 8'h0E;
      8'd2: r = 8'h0D;
      8'd3: r = 8'h0F;
      default: r = 8'h06;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] cursor_byte(input logic [7:0] row, input logic [7:0] col);
    logic [7:0] p;
    case (row)
      8'd1: p = 8'h40;
      8'd2: p = 8'h10;
      8'd3: p = 8'h50;
      default: p = 8'h00;
    endcase
    if (col <= 8'd15) p = p | col;
    return LCD_SET_DDRAM | p;
  endfunction

  // datapath commands from the controller
  typedef struct packed {
    logic       mir_wr;      // write mirror at char address
    logic       enq;         // push one entry
    logic [1:0] enq_kind;
    logic [7:0] enq_a;
    logic [7:0] enq_b;
    logic       copy;        // copy step: read mirror at copy_idx
    logic       copy_wr;     // write screen from previous copy read
    logic [5:0] copy_idx;
    logic       deq;         // pop head
    logic       scr_rd;      // read screen at refresh index
  } clq_cmd_t;

  typedef struct packed {
    logic       empty;
    logic       full;
    logic       addr_bad;
    logic [1:0] head_kind;
    logic [7:0] head_a;
    logic [7:0] head_b;
    logic [7:0] scr_q;
  } clq_sts_t;
endpackage

### rtl/clq_datapath.sv
// Mirror, screen store and command ring
module clq_datapath #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [7:0]        arg_a,
  input  logic [7:0]        arg_b,
  input  logic [5:0]        char_offset,
  input  logic [7:0]        char_data,
  input  logic [5:0]        scr_idx,
  input  clq_pkg::clq_cmd_t cmd,
  output clq_pkg::clq_sts_t sts
);
  localparam int PW = $clog2(QUEUE_DEPTH);

  logic [7:0] mirror_mem [64];
  logic [7:0] screen_mem [64];
  logic [63:0] mir_vld_r, scr_vld_r;
  logic [17:0] queue_mem [QUEUE_DEPTH];
  logic [17:0] head_q_r;
  logic [PW-1:0] head_r, tail_r, tail_inc, head_inc;
  logic [7:0] mir_q_r, scr_q_r;
  logic mir_qv_r, scr_qv_r;
  logic [5:0] copy_dst_r;
  logic [8:0] addr_sum;
  logic [5:0] char_addr;

  assign addr_sum = (arg_a <= 8'd3) ? ({1'b0, arg_a[1:0], 6'd0} >> 2) + {1'b0, arg_b}
                    + {3'd0, char_offset} : {3'd0, char_offset};
  assign char_addr = addr_sum[5:0];
  assign sts.addr_bad = (addr_sum > 9'd63);

  assign tail_inc = (tail_r == PW'(QUEUE_DEPTH - 1)) ? '0 : tail_r + 1'b1;
  assign head_inc = (head_r == PW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign sts.empty = (head_r == tail_r);
  assign sts.full  = (tail_inc == head_r);
  // head entry is read through a register and lags pointer moves; items are further apart than that lag
  assign sts.head_kind = head_q_r[17:16];
  assign sts.head_a    = head_q_r[15:8];
  assign sts.head_b    = head_q_r[7:0];
  assign sts.scr_q     = scr_qv_r ? scr_q_r : 8'd0;

  // row-interleaved: swap rows 1 and 2
  function automatic logic [5:0] swap_rows(input logic [5:0] i);
    return {i[4], i[5], i[3:0]};
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.mir_wr) mirror_mem[char_addr] <= char_data;
    if (cmd.copy) mir_q_r <= mirror_mem[cmd.copy_idx];
    if (cmd.copy) copy_dst_r <= swap_rows(cmd.copy_idx);
    if (cmd.copy_wr) screen_mem[copy_dst_r] <= mir_vld_r[swap_rows(copy_dst_r)] ? mir_q_r : 8'd0;
    if (cmd.scr_rd) scr_q_r <= screen_mem[scr_idx];
    if (cmd.enq) queue_mem[tail_r] <= {cmd.enq_kind, cmd.enq_a, cmd.enq_b};
    head_q_r <= queue_mem[head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mir_vld_r <= '0;
      scr_vld_r <= '0;
      head_r <= '0;
      tail_r <= '0;
      scr_qv_r <= 1'b0;
    end else begin
      if (cmd.mir_wr) mir_vld_r[char_addr] <= 1'b1;
      if (cmd.copy_wr) scr_vld_r[copy_dst_r] <= 1'b1;
      if (cmd.scr_rd) scr_qv_r <= scr_vld_r[scr_idx];
      if (cmd.enq) tail_r <= tail_inc;
      if (cmd.deq) head_r <= head_inc;
    end
  end
endmodule

### rtl/clq_ctrl.sv
// Sequencing controller for char, post and tick items
module clq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req_type,
  input  logic [1:0]        in_cmd,
  input  logic [7:0]        in_arg_a,
  input  logic [7:0]        in_arg_b,
  input  logic              in_last_char,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_lcd_valid,
  output logic              out_lcd_rs,
  output logic [7:0]        out_lcd_byte,
  output logic              out_work_pending,
  output logic              out_dropped,
  output logic [5:0]        scr_idx,
  output clq_pkg::clq_cmd_t cmd,
  input  clq_pkg::clq_sts_t sts
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_ENQ = 6'b000010, S_COPY = 6'b000100,
    S_TICK = 6'b001000, S_SCR = 6'b010000, S_OUT = 6'b100000
  } state_t;

  state_t state_r, state_nxt;
  logic [1:0] req_r, cmd_r;
  logic [7:0] a_r, b_r;
  logic [6:0] cnt_r, cnt_nxt;      // copy step counter
  logic [1:0] enq_step_r, enq_step_nxt;
  logic do_cur_r, do_cur_nxt;      // leading cursor post for last char
  logic drop_r, drop_nxt;
  logic [1:0] phase_r, phase_nxt;
  logic [5:0] ridx_r, ridx_nxt;
  logic ov_r, ov_nxt, lv_r, lv_nxt, rs_r, rs_nxt, pend_r, pend_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic use_scr_r, use_scr_nxt;
  logic acc;

  assign in_ready = (state_r == S_IDLE) && !ov_r;
  assign acc = in_valid && in_ready;
  assign out_valid = ov_r;
  assign out_lcd_valid = lv_r;
  assign out_lcd_rs = rs_r;
  assign out_lcd_byte = use_scr_r ? sts.scr_q : byte_r;
  assign out_work_pending = pend_r;
  assign out_dropped = drop_r;
  assign scr_idx = ridx_r;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    enq_step_nxt = enq_step_r;
    do_cur_nxt = do_cur_r;
    drop_nxt = drop_r;
    phase_nxt = phase_r;
    ridx_nxt = ridx_r;
    ov_nxt = ov_r && !out_ready;
    lv_nxt = lv_r; rs_nxt = rs_r; byte_nxt = byte_r; pend_nxt = pend_r;
    use_scr_nxt = use_scr_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          lv_nxt = 1'b0; rs_nxt = 1'b0; byte_nxt = 8'd0; pend_nxt = 1'b0;
          drop_nxt = 1'b0; use_scr_nxt = 1'b0; cnt_nxt = '0; enq_step_nxt = '0;
          do_cur_nxt = 1'b0;
          case (in_req_type)
            clq_pkg::REQ_CHAR: begin
              cmd.mir_wr = !sts.addr_bad;
              drop_nxt = sts.addr_bad;
              do_cur_nxt = in_last_char;
              state_nxt = in_last_char ? S_COPY : S_OUT;
            end
            clq_pkg::REQ_POST: begin
              state_nxt = (in_cmd == clq_pkg::K_UPDATE) ? S_COPY : S_ENQ;
            end
            clq_pkg::REQ_TICK: state_nxt = S_TICK;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_COPY: begin
        // optional cursor post goes ahead of the snapshot
        if (do_cur_r) begin
          cmd.enq = !sts.full;
          cmd.enq_kind = clq_pkg::K_CURSOR_POS;
          cmd.enq_a = a_r; cmd.enq_b = b_r;
          drop_nxt = drop_r | sts.full;
          do_cur_nxt = 1'b0;
        end else begin
          cmd.copy = !cnt_r[6];
          cmd.copy_idx = cnt_r[5:0];
          cmd.copy_wr = (cnt_r != 7'd0);
          cnt_nxt = cnt_r + 7'd1;
          if (cnt_r == 7'd64) state_nxt = S_ENQ;
        end
      end
      S_ENQ: begin
        cmd.enq = !sts.full;
        drop_nxt = drop_r | sts.full;
        if (req_r == clq_pkg::REQ_POST && cmd_r != clq_pkg::K_UPDATE) begin
          cmd.enq_kind = cmd_r; cmd.enq_a = a_r; cmd.enq_b = b_r;
          state_nxt = S_OUT;
        end else begin
          case (enq_step_r)
            2'd0: cmd.enq_kind = clq_pkg::K_CURSOR_POS;
            2'd1: cmd.enq_kind = clq_pkg::K_UPDATE;
            default: begin
              cmd.enq_kind = clq_pkg::K_CURSOR_POS;
              cmd.enq_b = 8'd15;
            end
          endcase
          enq_step_nxt = enq_step_r + 2'd1;
          if (enq_step_r == 2'd2) state_nxt = S_OUT;
        end
      end
      S_TICK: begin
        state_nxt = S_OUT;
        if (!sts.empty) begin
          pend_nxt = 1'b1;
          case (sts.head_kind)
            clq_pkg::K_CURSOR_POS: begin
              lv_nxt = 1'b1; byte_nxt = clq_pkg::cursor_byte(sts.head_a, sts.head_b);
              cmd.deq = 1'b1;
            end
            clq_pkg::K_CURSOR_MODE: begin
              if (sts.head_a <= 8'd4) begin
                lv_nxt = 1'b1; byte_nxt = clq_pkg::mode_byte(sts.head_a);
              end
              cmd.deq = 1'b1;
            end
            clq_pkg::K_FUNCTION: begin
              lv_nxt = 1'b1; byte_nxt = clq_pkg::LCD_FUNCTION;
              cmd.deq = 1'b1;
            end
            default: begin
              lv_nxt = 1'b1;
              case (phase_r)
                2'd0: begin
                  byte_nxt = clq_pkg::LCD_SET_DDRAM; phase_nxt = 2'd1; ridx_nxt = '0;
                end
                2'd2: begin
                  byte_nxt = clq_pkg::LCD_LINE2; phase_nxt = 2'd3;
                end
                default: begin
                  rs_nxt = 1'b1; use_scr_nxt = 1'b1;
                  cmd.scr_rd = 1'b1;
                  state_nxt = S_SCR;
                end
              endcase
            end
          endcase
        end
      end
      S_SCR: begin
        state_nxt = S_OUT;
        if (phase_r == 2'd1) begin
          if (ridx_r >= 6'd31) begin
            phase_nxt = 2'd2; ridx_nxt = 6'd32;
          end else ridx_nxt = ridx_r + 6'd1;
        end else begin
          if (ridx_r == 6'd63) begin
            phase_nxt = 2'd0; ridx_nxt = '0; cmd.deq = 1'b1;
          end else ridx_nxt = ridx_r + 6'd1;
        end
      end
      S_OUT: begin
        ov_nxt = 1'b1;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      req_r <= in_req_type; cmd_r <= in_cmd; a_r <= in_arg_a; b_r <= in_arg_b;
    end
    lv_r <= lv_nxt; rs_r <= rs_nxt; byte_r <= byte_nxt; pend_r <= pend_nxt;
    drop_r <= drop_nxt; use_scr_r <= use_scr_nxt; cnt_r <= cnt_nxt;
    enq_step_r <= enq_step_nxt; do_cur_r <= do_cur_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r <= 1'b0;
      phase_r <= '0;
      ridx_r <= '0;
    end else begin
      state_r <= state_nxt;
      ov_r <= ov_nxt;
      phase_r <= phase_nxt;
      ridx_r <= ridx_nxt;
    end
  end
endmodule

### rtl/char_lcd_refresh_queue_unit.sv
// Top level of the character display refresh queue
// One item at a time. A char that is not the last, or an ignored item, goes
// straight to the output state; a plain post passes through the enqueue state,
// a tick through the tick state and, if it sends a screen byte, the screen read
// state. An update (post or last char, which first queues a cursor post) runs
// a mirror-to-screen copy through the single-port stores, then queues requests.
// The result waits in an output register until taken; a new item is accepted
// from the cycle after it has been transferred. The ring holds QUEUE_DEPTH-1
// entries.
module char_lcd_refresh_queue_unit #(
  parameter int QUEUE_DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_req_type,
  input  logic [1:0] in_cmd,
  input  logic [7:0] in_arg_a,
  input  logic [7:0] in_arg_b,
  input  logic [5:0] in_char_offset,
  input  logic [7:0] in_char_data,
  input  logic       in_last_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_lcd_valid,
  output logic       out_lcd_rs,
  output logic [7:0] out_lcd_byte,
  output logic       out_work_pending,
  output logic       out_dropped
);
  clq_pkg::clq_cmd_t cmd;
  clq_pkg::clq_sts_t sts;
  logic [5:0] scr_idx;

  clq_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_req_type, .in_cmd, .in_arg_a, .in_arg_b,
    .in_last_char, .out_valid, .out_ready, .out_lcd_valid, .out_lcd_rs, .out_lcd_byte,
    .out_work_pending, .out_dropped, .scr_idx, .cmd, .sts
  );

  clq_datapath #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_dp (
    .clk, .rst_n, .arg_a(in_arg_a), .arg_b(in_arg_b), .char_offset(in_char_offset),
    .char_data(in_char_data), .scr_idx, .cmd, .sts
  );
endmodule

### rtl/clq_checker.sv
// Port-level checker for the refresh queue, bound to the top level
`include "char_lcd_refresh_queue_unit_macros.svh"
module clq_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_lcd_valid,
  input logic       out_lcd_rs,
  input logic [7:0] out_lcd_byte,
  input logic       out_work_pending,
  input logic       out_dropped
);
  `CLQ_ASSERT_IMP(a_no_accept_while_busy, clk, rst_n, out_valid, !in_ready)
  `CLQ_ASSERT_IMP(a_idle_bus_zero, clk, rst_n, out_valid && !out_lcd_valid, !out_lcd_rs && out_lcd_byte == 8'd0)
  `CLQ_ASSERT_IMP(a_write_needs_work, clk, rst_n, out_valid && out_lcd_valid, out_work_pending)
  `CLQ_ASSERT_IMP(a_tick_never_drops, clk, rst_n, out_valid && out_work_pending, !out_dropped)
  `CLQ_ASSERT_NXT(a_accept_no_result, clk, rst_n, in_valid && in_ready, !out_valid)
endmodule

bind char_lcd_refresh_queue_unit clq_checker u_clq_checker (
  .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .out_lcd_valid, .out_lcd_rs,
  .out_lcd_byte, .out_work_pending, .out_dropped
);
